@@ rtl/assert_macros.svh @@
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define CHK_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define CHK_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/bbpi_pkg.sv @@
package bbpi_pkg;

    localparam int VIN_SHIFT_DEF  = 4;
    localparam int VOUT_SHIFT_DEF = 4;
    localparam int DELAY_DEF      = 25;

    // register indexes on the config port
    localparam logic [2:0] REG_LOW_LIMIT = 3'd0;
    localparam logic [2:0] REG_MAX_LIMIT = 3'd1;
    localparam logic [2:0] REG_BOOST_THR = 3'd2;
    localparam logic [2:0] REG_BUCK_THR  = 3'd3;
    localparam logic [2:0] REG_TARGET    = 3'd4;
    localparam logic [2:0] REG_KP        = 3'd5;
    localparam logic [2:0] REG_KI        = 3'd6;
    localparam logic [2:0] REG_PERIOD    = 3'd7;

    localparam logic [9:0]  RST_LOW_LIMIT = 10'd0;
    localparam logic [9:0]  RST_MAX_LIMIT = 10'd1023;
    localparam logic [9:0]  RST_BOOST_THR = 10'd400;
    localparam logic [9:0]  RST_BUCK_THR  = 10'd600;
    localparam logic [9:0]  RST_TARGET    = 10'd470;
    localparam logic [15:0] RST_KP        = 16'd3277;
    localparam logic [15:0] RST_KI        = 16'd3277;
    localparam logic [14:0] RST_PERIOD    = 15'd1000;

    // lamp bits: [0] boost, [1] buck, [2] normal
    localparam logic [2:0] LAMP_OFF   = 3'b000;
    localparam logic [2:0] LAMP_BOOST = 3'b001;
    localparam logic [2:0] LAMP_BUCK  = 3'b010;
    localparam logic [2:0] LAMP_ALL   = 3'b111;
    localparam int         LAMP_NORMAL_BIT = 2;

    localparam logic signed [14:0] ERR_HI = 15'sd1024;
    localparam logic signed [14:0] ERR_LO = -15'sd1024;

    localparam logic [31:0] INTEG_MAX = 32'h7fff_ffff;
    localparam logic [31:0] INTEG_MIN = 32'h8000_0000;

    // floor(t / 3) = (t * RECIP3) >> RECIP_SHIFT, exact for t < 2**19
    localparam logic [17:0] RECIP3      = 18'd174763;
    localparam int          RECIP_SHIFT = 19;

    typedef struct packed {
        logic [9:0]  low_limit;
        logic [9:0]  max_limit;
        logic [9:0]  boost_thr;
        logic [9:0]  buck_thr;
        logic [9:0]  target;
        logic [15:0] kp;
        logic [15:0] ki;
        logic [14:0] period;
    } t_cfg;

    typedef struct packed {
        logic signed [14:0] err;
        logic signed [31:0] integ;
        logic               boost;
        logic               run;
        logic               force_low;
        logic               lamp_load;
        logic [2:0]         lamp_val;
    } t_ctrl;

    typedef struct packed {
        logic [15:0] duty;
        logic        run;
        logic        boost;
        logic        force_low;
        logic [2:0]  lamps;
    } t_res;

endpackage

@@ rtl/bbpi_ctrl.sv @@
module bbpi_ctrl
    import bbpi_pkg::*;
#(
    parameter int VIN_SHIFT  = VIN_SHIFT_DEF,
    parameter int VOUT_SHIFT = VOUT_SHIFT_DEF,
    parameter int DELAY      = DELAY_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic [13:0] i_vin_sum,
    input  logic [13:0] i_vout_sum,
    input  logic        i_sw,
    input  t_cfg        i_cfg,
    output t_ctrl       o_ctrl
);

    localparam logic [4:0] DLY = 5'(DELAY);

    logic               r_mode;
    logic [4:0]         r_cnt_boost;
    logic [4:0]         r_cnt_buck;
    logic [4:0]         r_cnt_fault;
    logic signed [31:0] r_integ;
    t_ctrl              r_ctrl;

    logic               n_mode;
    logic [4:0]         n_cnt_boost;
    logic [4:0]         n_cnt_buck;
    logic [4:0]         n_cnt_fault;
    logic signed [31:0] n_integ;
    t_ctrl              n_ctrl;

    logic [13:0]        w_vin;
    logic [13:0]        w_vout;
    logic               w_in_range;
    logic [4:0]         w_boost_dec;
    logic [4:0]         w_buck_dec;
    logic [4:0]         w_fault_dec;
    logic signed [14:0] w_err;
    logic signed [32:0] w_isum;

    assign w_vin  = i_vin_sum >> VIN_SHIFT;
    assign w_vout = i_vout_sum >> VOUT_SHIFT;
    assign w_in_range = (w_vin >= {4'b0, i_cfg.low_limit}) && (w_vin <= {4'b0, i_cfg.max_limit});
    assign w_boost_dec = r_cnt_boost - 5'd1;
    assign w_buck_dec  = r_cnt_buck - 5'd1;
    assign w_fault_dec = r_cnt_fault - 5'd1;
    assign w_err = $signed({5'b0, i_cfg.target}) - $signed({1'b0, w_vout});

    always_comb begin
        n_mode      = r_mode;
        n_cnt_boost = r_cnt_boost;
        n_cnt_buck  = r_cnt_buck;
        n_cnt_fault = r_cnt_fault;
        n_integ     = r_integ;
        w_isum      = '0;
        n_ctrl.run       = 1'b0;
        n_ctrl.force_low = 1'b0;
        n_ctrl.lamp_load = 1'b0;
        n_ctrl.lamp_val  = LAMP_OFF;

        if (!i_sw) begin
            n_integ          = '0;
            n_ctrl.force_low = 1'b1;
            n_ctrl.lamp_load = 1'b1;
            n_ctrl.lamp_val  = LAMP_OFF;
        end else if (w_in_range) begin
            n_ctrl.run = 1'b1;
            if (w_vin <= {4'b0, i_cfg.boost_thr}) begin
                if (w_boost_dec == 5'd0) begin
                    n_cnt_boost      = 5'd1;
                    n_cnt_buck       = DLY;
                    n_cnt_fault      = DLY;
                    n_ctrl.lamp_load = 1'b1;
                    n_ctrl.lamp_val  = LAMP_BOOST;
                    if (!r_mode) begin
                        n_integ = '0;
                    end
                    n_mode = 1'b1;
                end else begin
                    n_cnt_boost = w_boost_dec;
                end
            end else if (w_vin >= {4'b0, i_cfg.buck_thr}) begin
                if (w_buck_dec == 5'd0) begin
                    n_cnt_buck       = 5'd1;
                    n_cnt_boost      = DLY;
                    n_cnt_fault      = DLY;
                    n_ctrl.lamp_load = 1'b1;
                    n_ctrl.lamp_val  = LAMP_BUCK;
                    if (r_mode) begin
                        n_integ = '0;
                    end
                    n_mode = 1'b0;
                end else begin
                    n_cnt_buck = w_buck_dec;
                end
            end

            // integrate only small errors, saturating to 32 bits
            if (w_err > ERR_LO && w_err < ERR_HI) begin
                w_isum = {n_integ[31], n_integ} + {{18{w_err[14]}}, w_err};
                if (w_isum[32] != w_isum[31]) begin
                    n_integ = w_isum[32] ? INTEG_MIN : INTEG_MAX;
                end else begin
                    n_integ = w_isum[31:0];
                end
            end else begin
                n_integ = '0;
            end
        end else begin
            if (w_fault_dec == 5'd0) begin
                n_cnt_fault      = 5'd1;
                n_cnt_boost      = DLY;
                n_cnt_buck       = DLY;
                n_ctrl.lamp_load = 1'b1;
                n_ctrl.lamp_val  = LAMP_ALL;
                n_integ          = '0;
                n_ctrl.force_low = 1'b1;
            end else begin
                n_cnt_fault = w_fault_dec;
            end
        end

        n_ctrl.err   = w_err;
        n_ctrl.integ = n_integ;
        n_ctrl.boost = n_mode;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= 1'b0;
            r_cnt_boost <= DLY;
            r_cnt_buck  <= DLY;
            r_cnt_fault <= DLY;
            r_integ     <= '0;
        end else if (i_en) begin
            r_mode      <= n_mode;
            r_cnt_boost <= n_cnt_boost;
            r_cnt_buck  <= n_cnt_buck;
            r_cnt_fault <= n_cnt_fault;
            r_integ     <= n_integ;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ctrl <= n_ctrl;
        end
    end

    assign o_ctrl = r_ctrl;

endmodule

@@ rtl/bbpi_pi.sv @@
module bbpi_pi
    import bbpi_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_en,
    input  logic  i_v2,
    input  t_ctrl i_ctrl,
    input  t_cfg  i_cfg,
    output t_res  o_res
);

    // stage 2: products
    t_ctrl              r2_ctrl;
    logic signed [31:0] r2_pe;
    logic signed [48:0] r2_pi;

    // stage 3: clamped magnitude in units of 2**15, lamp state
    logic [17:0]        r3_t;
    logic               r3_run;
    logic               r3_boost;
    logic               r3_force;
    logic [2:0]         r_lamp;

    t_res               r4_res;

    logic signed [16:0] w_kp_s;
    logic signed [16:0] w_ki_s;
    logic signed [31:0] w_pe;
    logic signed [48:0] w_pi;
    logic signed [49:0] w_pi_sum;
    logic signed [49:0] w_neg;
    logic [16:0]        w_p3;
    logic [33:0]        w_lim;
    logic signed [49:0] w_lim_s;
    logic [32:0]        w_q;
    logic [2:0]         n_lamp;
    logic [35:0]        w_prod;
    logic [16:0]        w_d;
    logic [16:0]        w_dmax;
    logic [16:0]        w_duty;
    t_res               n_res;

    assign w_kp_s = {1'b0, i_cfg.kp};
    assign w_ki_s = {1'b0, i_cfg.ki};
    assign w_pe = i_ctrl.err * w_kp_s;
    assign w_pi = i_ctrl.integ * w_ki_s;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_ctrl <= i_ctrl;
            r2_pe   <= w_pe;
            r2_pi   <= w_pi;
        end
    end

    assign w_pi_sum = {{18{r2_pe[31]}}, r2_pe} + {r2_pi[48], r2_pi};
    assign w_neg    = -w_pi_sum;
    // limit = 3 * period in Q16
    assign w_p3    = {2'b0, i_cfg.period} + {1'b0, i_cfg.period, 1'b0};
    assign w_lim   = {1'b0, w_p3, 16'b0};
    assign w_lim_s = {16'b0, w_lim};

    always_comb begin
        if (r2_ctrl.boost) begin
            if (w_pi_sum >= w_lim_s) begin
                w_q = w_lim[32:0];
            end else if (w_pi_sum[49]) begin
                w_q = '0;
            end else begin
                w_q = w_pi_sum[32:0];
            end
        end else begin
            if (w_pi_sum <= -w_lim_s) begin
                w_q = w_lim[32:0];
            end else if (!w_pi_sum[49]) begin
                w_q = '0;
            end else begin
                w_q = w_neg[32:0];
            end
        end

        n_lamp = r2_ctrl.lamp_load ? r2_ctrl.lamp_val : r_lamp;
        if (r2_ctrl.run) begin
            n_lamp[LAMP_NORMAL_BIT] = (w_pi_sum <= 50'sd0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lamp <= LAMP_OFF;
        end else if (i_en && i_v2) begin
            r_lamp <= n_lamp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_t     <= w_q[32:15];
            r3_run   <= r2_ctrl.run;
            r3_boost <= r2_ctrl.boost;
            r3_force <= r2_ctrl.force_low;
        end
    end

    // stage 4: duty = floor(q * 2 / 3 / 2**16), limited per mode
    assign w_prod = r3_t * RECIP3;
    assign w_d    = w_prod[35:RECIP_SHIFT];
    assign w_dmax = r3_boost ? {1'b0, i_cfg.period, 1'b0} : {2'b0, i_cfg.period};
    assign w_duty = (w_d > w_dmax) ? w_dmax : w_d;

    always_comb begin
        n_res.duty      = r3_run ? w_duty[15:0] : 16'd0;
        n_res.run       = r3_run;
        n_res.boost     = r3_boost;
        n_res.force_low = r3_force;
        n_res.lamps     = r_lamp;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r4_res <= n_res;
        end
    end

    assign o_res = r4_res;

endmodule

@@ rtl/buck_boost_pi_regulator.sv @@
// Throughput: one tick per cycle unless a held output beat stalls the pipe; a
// five-register pipe (input, control/debounce, products, PI sum and clamp, duty
// scaling) with the integral updated in the control/debounce stage.
// Reset (synchronous, active low): registers to their defaults, debounce counters
// to DELAY, mode buck, integral and lamps cleared, pipe empty.
module buck_boost_pi_regulator
    import bbpi_pkg::*;
#(
    parameter int VIN_SHIFT  = VIN_SHIFT_DEF,
    parameter int VOUT_SHIFT = VOUT_SHIFT_DEF,
    parameter int DELAY      = DELAY_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // input_voltage_sum[13:0], output_voltage_sum[27:14]
    input  logic [0:0]  s_axis_tuser,  // switch_on[0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,  // duty_value[15:0]
    output logic [5:0]  m_axis_tuser,  // duty_valid, boost_active, force_drive_low,
                                       // boost_led, buck_led, normal_led
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    t_cfg        r_cfg;
    logic [4:0]  r_vld;
    logic [13:0] r0_vin;
    logic [13:0] r0_vout;
    logic        r0_sw;
    logic        w_adv;
    t_ctrl       w_ctrl;
    t_res        w_res;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.low_limit <= RST_LOW_LIMIT;
            r_cfg.max_limit <= RST_MAX_LIMIT;
            r_cfg.boost_thr <= RST_BOOST_THR;
            r_cfg.buck_thr  <= RST_BUCK_THR;
            r_cfg.target    <= RST_TARGET;
            r_cfg.kp        <= RST_KP;
            r_cfg.ki        <= RST_KI;
            r_cfg.period    <= RST_PERIOD;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_LOW_LIMIT: r_cfg.low_limit <= i_cfg_data[9:0];
                REG_MAX_LIMIT: r_cfg.max_limit <= i_cfg_data[9:0];
                REG_BOOST_THR: r_cfg.boost_thr <= i_cfg_data[9:0];
                REG_BUCK_THR:  r_cfg.buck_thr  <= i_cfg_data[9:0];
                REG_TARGET:    r_cfg.target    <= i_cfg_data[9:0];
                REG_KP:        r_cfg.kp        <= i_cfg_data;
                REG_KI:        r_cfg.ki        <= i_cfg_data;
                REG_PERIOD:    r_cfg.period    <= i_cfg_data[14:0];
                default: ;
            endcase
        end
    end

    // whole pipe moves together, stalled only by a held output beat
    assign w_adv = !r_vld[4] || m_axis_tready;
    assign s_axis_tready = w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= {r_vld[3:0], s_axis_tvalid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r0_vin  <= s_axis_tdata[13:0];
            r0_vout <= s_axis_tdata[27:14];
            r0_sw   <= s_axis_tuser[0];
        end
    end

    bbpi_ctrl #(
        .VIN_SHIFT  (VIN_SHIFT),
        .VOUT_SHIFT (VOUT_SHIFT),
        .DELAY      (DELAY)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (w_adv && r_vld[0]),
        .i_vin_sum  (r0_vin),
        .i_vout_sum (r0_vout),
        .i_sw       (r0_sw),
        .i_cfg      (r_cfg),
        .o_ctrl     (w_ctrl)
    );

    bbpi_pi u_pi (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_v2    (r_vld[2]),
        .i_ctrl  (w_ctrl),
        .i_cfg   (r_cfg),
        .o_res   (w_res)
    );

    assign m_axis_tvalid = r_vld[4];
    assign m_axis_tdata  = w_res.duty;
    assign m_axis_tuser  = {w_res.lamps[2], w_res.lamps[1], w_res.lamps[0],
                            w_res.force_low, w_res.boost, w_res.run};

endmodule

@@ rtl/bbpi_checker.sv @@
`include "assert_macros.svh"

module bbpi_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata,
    input logic [5:0]  m_axis_tuser
);

    `CHK_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled beat changed")

    `CHK_IMPLY(a_duty_zero, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tuser[0],
        m_axis_tdata == 16'd0, "duty set without update")

    `CHK_IMPLY(a_force_no_duty, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser[2],
        !m_axis_tuser[0], "duty update on a forced-low tick")

    `CHK_IMPLY(a_force_lamps, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser[2],
        m_axis_tuser[5:3] == 3'b000 || m_axis_tuser[5:3] == 3'b111, "lamps wrong when forced")

    `CHK_IMPLY(a_boost_normal, i_clk, i_rst_n,
        m_axis_tvalid && m_axis_tuser[0] && m_axis_tuser[1] && m_axis_tuser[5],
        m_axis_tdata == 16'd0, "boost duty nonzero with non-positive PI")

endmodule

bind buck_boost_pi_regulator bbpi_checker u_bbpi_checker (.*);
